/* hdl/offset_direct_index_table_defines.svh */
// Assertion macros shared by the RTL.
`ifndef OFFSET_DIRECT_INDEX_TABLE_DEFINES_SVH
`define OFFSET_DIRECT_INDEX_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ODIT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ODIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/odit_pkg.sv */
`default_nettype none

package odit_pkg;

    localparam int ID_W          = 31;
    localparam int POS_W         = 10;
    localparam int EPOCH_W       = 8;
    localparam int DEPTH_DEFAULT = 1024;

    typedef enum logic [1:0] {
        KIND_OBSERVE = 2'd0,
        KIND_ARM     = 2'd1,
        KIND_SET     = 2'd2,
        KIND_GET     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TAKEN     = 2'd1,
        ST_OUT_RANGE = 2'd2,
        ST_BAD_SPAN  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id_value;
        logic [ID_W-1:0]   entry_value;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [ID_W-1:0]   entry_out;
    } rsp_t;

endpackage

`default_nettype wire

/* hdl/odit_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read port, read-first.
module odit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/offset_direct_index_table.sv */
// A word taken on req passes stage 1, stage 2 and the rsp register.
// Throughput: one word per cycle unless rsp stalls or a sweep runs; set/get
// slot reads use the RAM's registered read port; set-after-set to one slot is forwarded.
// Reset: lowest id all ones, highest id and span zero, table disarmed. The
// slot RAM is then swept slot by slot with req_ready low; the same sweep
// follows every (2**EPOCH_W - 1)th arm, when the epoch tag wraps.
`default_nettype none
`include "offset_direct_index_table_defines.svh"

module offset_direct_index_table
    import odit_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SPAN_W = $clog2(DEPTH + 1);
    localparam int RAM_W  = EPOCH_W + ID_W;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // ---------------------------------------------------------------
    // Control and tracked state
    // ---------------------------------------------------------------
    logic                s1_valid_reg, s1_valid_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]     lowest_reg, lowest_next;
    logic [ID_W-1:0]     highest_reg, highest_next;
    logic [SPAN_W-1:0]   span_count_reg, span_count_next;
    // Epoch tag: a slot is valid when its stored tag equals the current one.
    // Arm bumps the tag, which empties the whole table at once.
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic                clearing_reg, clearing_next;
    logic [ADDR_W-1:0]   clear_cnt_reg, clear_cnt_next;

    // Payload registers
    req_t                s1_reg;
    kind_t               s2_kind_reg;
    logic                s2_in_span_reg;
    logic                s2_bad_span_reg;
    logic [ADDR_W-1:0]   s2_addr_reg;
    logic [POS_W-1:0]    s2_pos_reg;
    logic [ID_W-1:0]     s2_entry_reg;
    logic                s2_fwd_reg;
    logic [ID_W-1:0]     s2_fwd_entry_reg;
    rsp_t                rsp_reg, rsp_next;

    logic                s1_adv, s2_adv;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign s2_adv    = s2_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign s1_adv    = s1_valid_reg && !clearing_reg && (!s2_valid_reg || s2_adv);
    assign req_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // Stage 1: offset, range check, arm span; RAM read issued
    // ---------------------------------------------------------------
    logic [ID_W-1:0]     s1_offset;
    logic                s1_in_span;
    logic [ADDR_W-1:0]   s1_addr;
    logic [ID_W-1:0]     arm_diff;
    logic [ID_W:0]       arm_span;
    logic                arm_empty;
    logic                arm_bad;

    assign s1_offset  = s1_reg.id_value - lowest_reg;
    assign s1_in_span = (s1_reg.id_value >= lowest_reg)
                     && (s1_offset < {{(ID_W-SPAN_W){1'b0}}, span_count_reg});
    assign s1_addr    = s1_offset[ADDR_W-1:0];

    assign arm_diff   = highest_reg - lowest_reg;
    assign arm_span   = {1'b0, arm_diff} + (ID_W+1)'(1);
    assign arm_empty  = highest_reg < lowest_reg;
    assign arm_bad    = arm_empty || (arm_span > (ID_W+1)'(DEPTH));

    // ---------------------------------------------------------------
    // Stage 2: slot lookup, result, RAM write
    // ---------------------------------------------------------------
    logic [RAM_W-1:0]    ram_rdata;
    logic                slot_hit;
    logic [ID_W-1:0]     slot_entry;
    logic                s2_wr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;

    assign slot_hit   = s2_fwd_reg || (ram_rdata[RAM_W-1:ID_W] == epoch_reg);
    assign slot_entry = s2_fwd_reg ? s2_fwd_entry_reg : ram_rdata[ID_W-1:0];
    assign s2_wr      = s2_adv && (s2_kind_reg == KIND_SET) && s2_in_span_reg
                     && !slot_hit;

    // The sweep writes tag zero, which no live epoch uses.
    assign ram_we    = clearing_reg || s2_wr;
    assign ram_waddr = clearing_reg ? clear_cnt_reg : s2_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : {epoch_reg, s2_entry_reg};

    odit_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s1_adv),
        .raddr (s1_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rsp_next = '0;
        rsp_next.status = ST_OK;
        unique case (s2_kind_reg)
            KIND_OBSERVE:
            begin
                rsp_next.status = ST_OK;
            end
            KIND_ARM:
            begin
                rsp_next.status = s2_bad_span_reg ? ST_BAD_SPAN : ST_OK;
            end
            KIND_SET:
            begin
                if (!s2_in_span_reg)
                begin
                    rsp_next.status = ST_OUT_RANGE;
                end
                else
                begin
                    rsp_next.position = s2_pos_reg;
                    rsp_next.status   = slot_hit ? ST_TAKEN : ST_OK;
                end
            end
            KIND_GET:
            begin
                if (!s2_in_span_reg)
                begin
                    rsp_next.status = ST_OUT_RANGE;
                end
                else if (slot_hit)
                begin
                    rsp_next.found     = 1'b1;
                    rsp_next.entry_out = slot_entry;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s2_valid_next   = s2_valid_reg;
        rsp_valid_next  = rsp_valid_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;
        span_count_next = span_count_reg;
        epoch_next      = epoch_reg;
        clearing_next   = clearing_reg;
        clear_cnt_next  = clear_cnt_reg;

        if (req_valid && req_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end

        if (s2_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Tracked state moves as a word leaves stage 1, so the word behind
        // it sees the update.
        if (s1_adv && (s1_reg.kind == KIND_OBSERVE))
        begin
            if (s1_reg.id_value > highest_reg)
            begin
                highest_next = s1_reg.id_value;
            end
            if (s1_reg.id_value < lowest_reg)
            begin
                lowest_next = s1_reg.id_value;
            end
        end

        if (s1_adv && (s1_reg.kind == KIND_ARM))
        begin
            span_count_next = arm_bad ? '0 : arm_span[SPAN_W-1:0];
            if (epoch_reg == EPOCH_MAX)
            begin
                epoch_next     = EPOCH_W'(1);
                clearing_next  = 1'b1;
                clear_cnt_next = '0;
            end
            else
            begin
                epoch_next = epoch_reg + EPOCH_W'(1);
            end
        end

        if (clearing_reg)
        begin
            clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
            if (clear_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            lowest_reg     <= '1;
            highest_reg    <= '0;
            span_count_reg <= '0;
            epoch_reg      <= EPOCH_W'(1);
            clearing_reg   <= 1'b1;
            clear_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            lowest_reg     <= lowest_next;
            highest_reg    <= highest_next;
            span_count_reg <= span_count_next;
            epoch_reg      <= epoch_next;
            clearing_reg   <= clearing_next;
            clear_cnt_reg  <= clear_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_reg <= req;
        end
        if (s1_adv)
        begin
            s2_kind_reg      <= s1_reg.kind;
            s2_in_span_reg   <= s1_in_span;
            s2_bad_span_reg  <= arm_bad;
            s2_addr_reg      <= s1_addr;
            s2_pos_reg       <= s1_offset[POS_W-1:0];
            s2_entry_reg     <= s1_reg.entry_value;
            // Slot written by the word ahead this very edge: RAM still
            // returns the old contents, so carry the new entry along.
            s2_fwd_reg       <= s2_wr && (s2_addr_reg == s1_addr);
            s2_fwd_entry_reg <= s2_entry_reg;
        end
        if (s2_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ODIT_ASSERT_IMPL(a_no_accept_in_sweep, clearing_reg, !req_ready && !s1_adv,
        "word taken during RAM sweep")
    `ODIT_ASSERT_IMPL(a_write_source, ram_we && !clearing_reg,
        s2_adv && (s2_kind_reg == KIND_SET) && s2_in_span_reg,
        "slot write without an advancing set")
    `ODIT_ASSERT_IMPL(a_span_bound, 1'b1, span_count_reg <= SPAN_W'(DEPTH),
        "span beyond table depth")
    `ODIT_ASSERT_IMPL(a_epoch_live, 1'b1, epoch_reg != '0,
        "epoch tag collides with swept tag")
    `ODIT_ASSERT_NEXT(a_wrap_sweeps,
        s1_adv && (s1_reg.kind == KIND_ARM) && (epoch_reg == EPOCH_MAX),
        clearing_reg && (epoch_reg == EPOCH_W'(1)),
        "epoch wrap without sweep")

endmodule

`default_nettype wire
